[rtl/chacha_pkg.sv]
// Shared types, constants and round functions for the ChaCha20 stream cipher.
`default_nettype none

package chacha_pkg;

   // Block input constant words ("expand 32-byte k")
   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   // Entries in the front/back queue
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [63:0] in_data;
      logic [3:0]  byte_count;
      logic        last_chunk;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [3:0]  out_count;
      logic        out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] key_word_0;
      logic [63:0] key_word_1;
      logic [63:0] key_word_2;
      logic [63:0] key_word_3;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
      logic [31:0] start_counter;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_KEY_WORD_0    = 3'd0,
      REG_KEY_WORD_1    = 3'd1,
      REG_KEY_WORD_2    = 3'd2,
      REG_KEY_WORD_3    = 3'd3,
      REG_NONCE_LOW     = 3'd4,
      REG_NONCE_HIGH    = 3'd5,
      REG_START_COUNTER = 3'd6
   } cfg_reg_type;

   // 16-word cipher state, word 0 in the low bits
   typedef logic [15:0][31:0] state_type;
   // Keystream block as eight 64-bit words, same bit layout as state_type
   typedef logic [7:0][63:0]  block_type;

   // Queued transaction, tagged by the front end
   typedef struct packed {
      req_payload_type item;
      logic            new_block;
      logic [2:0]      word_idx;
      logic [31:0]     ctr;
   } queue_entry_type;

   typedef struct packed {
      logic start;
      logic abort;
   } core_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] ctr;
   } core_sts_type;

   function automatic logic [3:0][31:0] quarter_round(logic [31:0] a, logic [31:0] b,
                                                      logic [31:0] c, logic [31:0] d);
      logic [31:0] ta;
      logic [31:0] tb;
      logic [31:0] tc;
      logic [31:0] td;
      ta = a + b;  td = d ^ ta;  td = {td[15:0], td[31:16]};
      tc = c + td; tb = b ^ tc;  tb = {tb[19:0], tb[31:20]};
      ta = ta + tb; td = td ^ ta; td = {td[23:0], td[31:24]};
      tc = tc + td; tb = tb ^ tc; tb = {tb[24:0], tb[31:25]};
      return {td, tc, tb, ta};
   endfunction

   // One column round (diag = 0) or diagonal round (diag = 1): four independent lanes
   function automatic state_type round_fn(state_type x, logic diag);
      state_type        y;
      logic [3:0][31:0] q;
      logic [1:0]       ln;
      logic [1:0]       sb;
      logic [1:0]       sc;
      logic [1:0]       sd;
      logic [3:0]       ia;
      logic [3:0]       ib;
      logic [3:0]       ic;
      logic [3:0]       id;
      y  = x;
      sb = diag ? 2'd1 : 2'd0;
      sc = diag ? 2'd2 : 2'd0;
      sd = diag ? 2'd3 : 2'd0;
      for (int i = 0; i < 4; i++) begin
         ln = 2'(i);
         ia = {2'b00, ln};
         ib = {2'b01, 2'(ln + sb)};
         ic = {2'b10, 2'(ln + sc)};
         id = {2'b11, 2'(ln + sd)};
         q  = quarter_round(x[ia], x[ib], x[ic], x[id]);
         y[ia] = q[0];
         y[ib] = q[1];
         y[ic] = q[2];
         y[id] = q[3];
      end
      return y;
   endfunction

   function automatic state_type init_state(cfg_type cfg, logic [31:0] ctr);
      state_type s;
      s[0]  = SIGMA_0;
      s[1]  = SIGMA_1;
      s[2]  = SIGMA_2;
      s[3]  = SIGMA_3;
      s[4]  = cfg.key_word_0[31:0];
      s[5]  = cfg.key_word_0[63:32];
      s[6]  = cfg.key_word_1[31:0];
      s[7]  = cfg.key_word_1[63:32];
      s[8]  = cfg.key_word_2[31:0];
      s[9]  = cfg.key_word_2[63:32];
      s[10] = cfg.key_word_3[31:0];
      s[11] = cfg.key_word_3[63:32];
      s[12] = ctr;
      s[13] = cfg.nonce_low[31:0];
      s[14] = cfg.nonce_low[63:32];
      s[15] = cfg.nonce_high;
      return s;
   endfunction

   // Keep the low bytes given by count; counts above eight keep all eight
   function automatic logic [63:0] byte_mask(logic [3:0] count);
      logic [63:0] m;
      m = '0;
      if (count >= 4'd8) begin
         m = '1;
      end else begin
         for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < count) ? 8'hFF : 8'h00;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[rtl/chacha_front.sv]
// Front end: accepts transactions and tags them with block counter and word position.
`default_nettype none

module chacha_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire chacha_pkg::req_payload_type  req_payload,
   input  wire logic [31:0]                  start_counter,
   input  wire logic                         full,
   output logic                              push,
   output chacha_pkg::queue_entry_type       entry
);

   logic [2:0]  word_pos_ff, word_pos_in;
   logic [31:0] blk_cnt_ff,  blk_cnt_in;
   logic        blk_rdy_ff,  blk_rdy_in;

   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      entry.item      = req_payload;
      entry.new_block = !blk_rdy_ff;
      entry.word_idx  = word_pos_ff;
      entry.ctr       = start_counter + blk_cnt_ff;
   end

   always_comb begin
      word_pos_in = word_pos_ff;
      blk_cnt_in  = blk_cnt_ff;
      blk_rdy_in  = blk_rdy_ff;
      if (push) begin
         blk_cnt_in  = blk_rdy_ff ? blk_cnt_ff : blk_cnt_ff + 32'd1;
         word_pos_in = word_pos_ff + 3'd1;
         blk_rdy_in  = (word_pos_ff != 3'd7);
         if (req_payload.last_chunk) begin
            word_pos_in = '0;
            blk_cnt_in  = '0;
            blk_rdy_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_pos_ff <= '0;
         blk_cnt_ff  <= '0;
         blk_rdy_ff  <= 1'b0;
      end else begin
         word_pos_ff <= word_pos_in;
         blk_cnt_ff  <= blk_cnt_in;
         blk_rdy_ff  <= blk_rdy_in;
      end
   end

endmodule

`default_nettype wire

[rtl/chacha_queue.sv]
// Short FIFO of tagged transactions between front end and back end.
`default_nettype none

module chacha_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire chacha_pkg::queue_entry_type  push_entry,
   output logic                              full,
   input  wire logic                         pop,
   output logic                              head_valid,
   output chacha_pkg::queue_entry_type       head
);

   localparam int DEPTH = chacha_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   chacha_pkg::queue_entry_type mem_ff [DEPTH];
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

[rtl/chacha_core.sv]
// Iterative ChaCha block core: one round per cycle, then the feed-forward add.
`default_nettype none

module chacha_core #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire chacha_pkg::core_ctl_type  ctl,
   input  wire chacha_pkg::state_type     start_state,
   input  wire logic [31:0]               start_ctr,
   output chacha_pkg::core_sts_type       sts,
   output chacha_pkg::block_type          block
);

   localparam int          ROUNDS     = 2 * DOUBLE_ROUNDS;
   localparam int          RW         = $clog2(ROUNDS);
   localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

   logic                  busy_ff, busy_in;
   logic                  fin_ff,  fin_in;
   logic [RW-1:0]         rnd_ff,  rnd_in;
   logic [31:0]           ctr_ff,  ctr_in;
   chacha_pkg::state_type s_ff,    s_in;
   chacha_pkg::state_type x_ff,    x_in;
   chacha_pkg::state_type sum;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = fin_ff;
      rnd_in  = rnd_ff;
      ctr_in  = ctr_ff;
      s_in    = s_ff;
      x_in    = x_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         fin_in  = 1'b0;
         rnd_in  = '0;
         ctr_in  = start_ctr;
         s_in    = start_state;
         x_in    = start_state;
      end else if (ctl.abort || fin_ff) begin
         busy_in = 1'b0;
         fin_in  = 1'b0;
      end else if (busy_ff) begin
         x_in = chacha_pkg::round_fn(x_ff, rnd_ff[0]);
         if (rnd_ff == LAST_ROUND) begin
            fin_in = 1'b1;
         end else begin
            rnd_in = rnd_ff + 1'b1;
         end
      end
   end

   // Feed-forward add; valid while fin_ff is high
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         sum[k] = x_ff[k] + s_ff[k];
      end
      block = chacha_pkg::block_type'(sum);
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = fin_ff;
      sts.ctr  = ctr_ff;
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      s_ff   <= s_in;
      x_ff   <= x_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         rnd_ff  <= rnd_in;
      end
   end

`ifndef SYNTHESIS
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (fin_ff && !ctl.start) |=> !busy_ff)
      else $error("core still busy after finishing");
`endif

endmodule

`default_nettype wire

[rtl/chacha_back.sv]
// Back end: keystream block buffers, block core control, XOR and output register.
`default_nettype none

module chacha_back #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire chacha_pkg::queue_entry_type  head,
   output logic                              pop,
   input  wire chacha_pkg::cfg_type          cfg,
   input  wire logic                         cfg_wr,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output chacha_pkg::rsp_payload_type       rsp_payload
);

   chacha_pkg::block_type       cur_ff,       cur_in;
   chacha_pkg::block_type       nxt_ff,       nxt_in;
   logic                        nxt_valid_ff, nxt_valid_in;
   logic [31:0]                 nxt_ctr_ff,   nxt_ctr_in;
   logic                        spec_pend_ff, spec_pend_in;
   logic [31:0]                 spec_ctr_ff,  spec_ctr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   chacha_pkg::rsp_payload_type rsp_ff,       rsp_in;

   chacha_pkg::core_ctl_type ctl;
   chacha_pkg::core_sts_type sts;
   chacha_pkg::block_type    core_block;
   chacha_pkg::state_type    start_state;
   logic [31:0]              start_ctr;

   logic        nxt_hit;
   logic        core_hit;
   logic        ks_ok;
   logic        out_free;
   logic        fire;
   logic        demand;
   logic        spec_go;
   logic [63:0] ks_word;

   chacha_core #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .start_state (start_state),
      .start_ctr   (start_ctr),
      .sts         (sts),
      .block       (core_block)
   );

   always_comb begin
      nxt_hit  = nxt_valid_ff && (nxt_ctr_ff == head.ctr);
      core_hit = sts.busy && (sts.ctr == head.ctr);
      ks_ok    = head.new_block ? nxt_hit : 1'b1;
      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = head_valid && ks_ok && out_free;
      // Start the core for the head's block unless it is on hand or under way
      demand   = head_valid && head.new_block && !nxt_hit && !core_hit && !cfg_wr;
      // Otherwise work ahead on the block after the one just taken
      spec_go  = !demand && spec_pend_ff && !sts.busy && !nxt_valid_ff && !cfg_wr;
      ctl.start   = demand || spec_go;
      ctl.abort   = cfg_wr;
      start_ctr   = demand ? head.ctr : spec_ctr_ff;
      start_state = chacha_pkg::init_state(cfg, start_ctr);
      ks_word     = head.new_block ? nxt_ff[head.word_idx] : cur_ff[head.word_idx];
      pop         = fire;
   end

   always_comb begin
      rsp_in.out_data  = (head.item.in_data ^ ks_word) &
                         chacha_pkg::byte_mask(head.item.byte_count);
      rsp_in.out_count = head.item.byte_count;
      rsp_in.out_last  = head.item.last_chunk;

      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

      cur_in     = (fire && head.new_block) ? nxt_ff : cur_ff;
      nxt_in     = sts.done ? core_block : nxt_ff;
      nxt_ctr_in = sts.done ? sts.ctr : nxt_ctr_ff;

      nxt_valid_in = nxt_valid_ff;
      if (cfg_wr || ctl.start) begin
         nxt_valid_in = 1'b0;
      end else if (sts.done) begin
         nxt_valid_in = 1'b1;
      end else if (fire && head.new_block) begin
         nxt_valid_in = 1'b0;
      end

      spec_pend_in = spec_pend_ff;
      spec_ctr_in  = spec_ctr_ff;
      if (fire && head.new_block) begin
         spec_pend_in = 1'b1;
         spec_ctr_in  = head.ctr + 32'd1;
      end else if (cfg_wr || ctl.start) begin
         spec_pend_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      nxt_ctr_ff  <= nxt_ctr_in;
      spec_ctr_ff <= spec_ctr_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_valid_ff <= 1'b0;
         spec_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nxt_valid_ff <= nxt_valid_in;
         spec_pend_ff <= spec_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_nxt_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      nxt_valid_ff |-> !sts.busy)
      else $error("core running while an unused block is buffered");
`endif

endmodule

`default_nettype wire

[rtl/chacha20_stream_cipher.sv]
// Top level of the ChaCha20 stream cipher: register file, front end, queue and back end.
// With the keystream block on hand, an accepted transaction goes through the queue and the
//   result register; the first chunk of a block not worked ahead also waits for the block core.
// Throughput: one transaction per cycle within a block while results are not stalled; sustained,
//   the core makes one block at a time (one round per cycle, then finish and hand-off).
// Reset (synchronous, active high) zeroes the registers and empties queue and buffers.
`default_nettype none

module chacha20_stream_cipher #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input transactions
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire chacha_pkg::req_payload_type  req_payload,
   // result transactions
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output chacha_pkg::rsp_payload_type       rsp_payload,
   // register port, one 64-bit register every 8 bytes
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [5:0]                   paddr,
   input  wire logic [63:0]                  pwdata,
   output logic [63:0]                       prdata,
   output logic                              pready
);

   chacha_pkg::cfg_type         cfg_ff, cfg_in;
   chacha_pkg::cfg_reg_type     reg_sel;
   logic                        cfg_wr;

   logic                        push;
   chacha_pkg::queue_entry_type push_entry;
   logic                        full;
   logic                        pop;
   logic                        head_valid;
   chacha_pkg::queue_entry_type head;

   // ------------------------------------------------------------------
   // Register file. Writes land in the access phase; pready never waits.
   // Any write also drops keystream worked ahead with the old key.
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign reg_sel = chacha_pkg::cfg_reg_type'(paddr[5:3]);
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_sel)
            chacha_pkg::REG_KEY_WORD_0:    cfg_in.key_word_0    = pwdata;
            chacha_pkg::REG_KEY_WORD_1:    cfg_in.key_word_1    = pwdata;
            chacha_pkg::REG_KEY_WORD_2:    cfg_in.key_word_2    = pwdata;
            chacha_pkg::REG_KEY_WORD_3:    cfg_in.key_word_3    = pwdata;
            chacha_pkg::REG_NONCE_LOW:     cfg_in.nonce_low     = pwdata;
            chacha_pkg::REG_NONCE_HIGH:    cfg_in.nonce_high    = pwdata[31:0];
            chacha_pkg::REG_START_COUNTER: cfg_in.start_counter = pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         chacha_pkg::REG_KEY_WORD_0:    prdata = cfg_ff.key_word_0;
         chacha_pkg::REG_KEY_WORD_1:    prdata = cfg_ff.key_word_1;
         chacha_pkg::REG_KEY_WORD_2:    prdata = cfg_ff.key_word_2;
         chacha_pkg::REG_KEY_WORD_3:    prdata = cfg_ff.key_word_3;
         chacha_pkg::REG_NONCE_LOW:     prdata = cfg_ff.nonce_low;
         chacha_pkg::REG_NONCE_HIGH:    prdata = {32'd0, cfg_ff.nonce_high};
         chacha_pkg::REG_START_COUNTER: prdata = {32'd0, cfg_ff.start_counter};
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------
   // Front end: tracks word position and block count per message and tags
   // each transaction with its keystream word and absolute block counter.
   // ------------------------------------------------------------------
   chacha_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .start_counter (cfg_ff.start_counter),
      .full          (full),
      .push          (push),
      .entry         (push_entry)
   );

   // Decouples acceptance from keystream generation stalls
   chacha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // ------------------------------------------------------------------
   // Back end: current and next keystream blocks, the iterative block core
   // (which works ahead on counter+1), XOR/mask and the result register.
   // ------------------------------------------------------------------
   chacha_back #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .cfg         (cfg_ff),
      .cfg_wr      (cfg_wr),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
